### rtl/gsfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and tables of the sentence and frame parser.
// No dependencies; used by gsfp_step and the top level through scoped names.
package gsfp_pkg;

  localparam int ID_LEN     = 5;
  localparam int KIND_COUNT = 6;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] ACK_CLASS   = 8'h05;
  localparam logic [7:0] ACK_MSG_ID  = 8'h01;
  localparam logic [7:0] NAV_CLASS   = 8'h06;
  localparam logic [7:0] NAV_MSG_ID  = 8'h24;
  localparam logic [7:0] FIELD_MAX   = 8'hFF;

  localparam logic [ID_LEN*8-1:0] KIND_NAMES [KIND_COUNT] = '{
    "GPVTG", "GPGGA", "GPRMC", "GPGSA", "GPGSV", "GPGLL"
  };

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ID    = 4'd1,
    PH_DATA  = 4'd2,
    PH_CK1   = 4'd3,
    PH_CK2   = 4'd4,
    PH_SYNC2 = 4'd5,
    PH_CLASS = 4'd6,
    PH_MSGID = 4'd7,
    PH_LEN1  = 4'd8,
    PH_LEN2  = 4'd9,
    PH_BODY  = 4'd10,
    PH_CKA   = 4'd11,
    PH_CKB   = 4'd12
  } phase_t;

  typedef struct packed {
    logic       sentence_end;
    logic       checksum_good;
    logic [2:0] sentence_kind;
    logic       data_byte_valid;
    logic [7:0] field_index;
    logic [7:0] data_char;
    logic       ack_confirmed;
  } result_t;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "A" && c <= "F") begin
      v = c - 8'h41 + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      v = c - 8'h61 + 8'd10;
    end else begin
      v = c - 8'h30;
    end
    return v;
  endfunction

endpackage

### rtl/gsfp_step.sv
`timescale 1ns / 1ps
// Parser state and the per-byte update of text sentences and binary frames.
// Depends on gsfp_pkg.
module gsfp_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output gsfp_pkg::result_t res
);

  gsfp_pkg::phase_t parse_phase, parse_phase_next;
  logic [2:0]  id_count, id_count_next;
  logic [7:0]  id_chars [gsfp_pkg::ID_LEN];
  logic [7:0]  id_chars_next [gsfp_pkg::ID_LEN];
  logic [7:0]  running_xor, running_xor_next;
  logic [2:0]  current_kind, current_kind_next;
  logic [7:0]  comma_count, comma_count_next;
  logic [7:0]  frame_class, frame_class_next;
  logic [7:0]  frame_msg_id, frame_msg_id_next;
  logic [15:0] body_length, body_length_next;
  logic [15:0] body_count, body_count_next;
  logic [7:0]  acked_class, acked_class_next;
  logic [7:0]  acked_msg, acked_msg_next;
  logic        confirmed, confirmed_next;

  logic [2:0]  match_kind;
  logic        match_hit;
  logic [15:0] body_count_inc;
  logic [7:0]  ck_digit;

  always_comb begin
    match_kind = 3'd0;
    match_hit  = 1'b0;
    for (int k = gsfp_pkg::KIND_COUNT - 1; k >= 0; k--) begin
      logic same;
      same = 1'b1;
      for (int i = 0; i < gsfp_pkg::ID_LEN; i++) begin
        if (id_chars_next[i] != gsfp_pkg::KIND_NAMES[k][8*(gsfp_pkg::ID_LEN-1-i) +: 8]) begin
          same = 1'b0;
        end
      end
      if (same) begin
        match_kind = 3'(k);
        match_hit  = 1'b1;
      end
    end
  end

  assign body_count_inc = body_count + 16'd1;
  assign ck_digit       = gsfp_pkg::hex_value(rx_byte);

  always_comb begin
    parse_phase_next  = parse_phase;
    id_count_next     = id_count;
    id_chars_next     = id_chars;
    running_xor_next  = running_xor;
    current_kind_next = current_kind;
    comma_count_next  = comma_count;
    frame_class_next  = frame_class;
    frame_msg_id_next = frame_msg_id;
    body_length_next  = body_length;
    body_count_next   = body_count;
    acked_class_next  = acked_class;
    acked_msg_next    = acked_msg;
    confirmed_next    = confirmed;
    res               = '0;

    unique case (parse_phase)
      gsfp_pkg::PH_ID: begin
        if (id_count < 3'(gsfp_pkg::ID_LEN)) begin
          id_chars_next[id_count] = rx_byte;
        end
        running_xor_next = running_xor ^ rx_byte;
        id_count_next    = id_count + 3'd1;
        if (id_count_next >= 3'(gsfp_pkg::ID_LEN)) begin
          id_count_next    = 3'd0;
          comma_count_next = 8'd0;
          if (match_hit) begin
            current_kind_next = match_kind;
            parse_phase_next  = gsfp_pkg::PH_DATA;
          end else begin
            parse_phase_next = gsfp_pkg::PH_IDLE;
          end
        end
      end
      gsfp_pkg::PH_DATA: begin
        if (rx_byte == gsfp_pkg::CHAR_STAR) begin
          parse_phase_next = gsfp_pkg::PH_CK1;
        end else begin
          running_xor_next    = running_xor ^ rx_byte;
          res.data_byte_valid = 1'b1;
          res.field_index     = comma_count;
          res.data_char       = rx_byte;
          if (rx_byte == gsfp_pkg::CHAR_COMMA && comma_count != gsfp_pkg::FIELD_MAX) begin
            comma_count_next = comma_count + 8'd1;
          end
        end
      end
      gsfp_pkg::PH_CK1: begin
        running_xor_next = running_xor - {ck_digit[3:0], 4'd0};
        parse_phase_next = gsfp_pkg::PH_CK2;
      end
      gsfp_pkg::PH_CK2: begin
        running_xor_next  = running_xor - ck_digit;
        res.sentence_end  = 1'b1;
        res.checksum_good = (running_xor_next == 8'd0);
        parse_phase_next  = gsfp_pkg::PH_IDLE;
      end
      gsfp_pkg::PH_SYNC2: begin
        parse_phase_next = (rx_byte == gsfp_pkg::SYNC_SECOND) ? gsfp_pkg::PH_CLASS
                                                               : gsfp_pkg::PH_IDLE;
      end
      gsfp_pkg::PH_CLASS: begin
        frame_class_next = rx_byte;
        parse_phase_next = gsfp_pkg::PH_MSGID;
      end
      gsfp_pkg::PH_MSGID: begin
        frame_msg_id_next = rx_byte;
        parse_phase_next  = gsfp_pkg::PH_LEN1;
      end
      gsfp_pkg::PH_LEN1: begin
        body_length_next = {8'd0, rx_byte};
        parse_phase_next = gsfp_pkg::PH_LEN2;
      end
      gsfp_pkg::PH_LEN2: begin
        body_length_next = {rx_byte, body_length[7:0]};
        body_count_next  = 16'd0;
        parse_phase_next = (body_length_next == 16'd0) ? gsfp_pkg::PH_CKA
                                                        : gsfp_pkg::PH_BODY;
      end
      gsfp_pkg::PH_BODY: begin
        if (frame_class == gsfp_pkg::ACK_CLASS && frame_msg_id == gsfp_pkg::ACK_MSG_ID) begin
          if (body_count == 16'd0) begin
            acked_class_next = rx_byte;
          end else if (body_count == 16'd1) begin
            acked_msg_next = rx_byte;
          end
        end
        body_count_next = body_count_inc;
        if (body_count_inc == body_length) begin
          parse_phase_next = gsfp_pkg::PH_CKA;
        end
      end
      gsfp_pkg::PH_CKA: begin
        parse_phase_next = gsfp_pkg::PH_CKB;
      end
      gsfp_pkg::PH_CKB: begin
        if (acked_class == gsfp_pkg::NAV_CLASS && acked_msg == gsfp_pkg::NAV_MSG_ID) begin
          confirmed_next = 1'b1;
        end
        parse_phase_next = gsfp_pkg::PH_IDLE;
      end
      default: begin
        parse_phase_next = gsfp_pkg::PH_IDLE;
        if (rx_byte == gsfp_pkg::CHAR_DOLLAR) begin
          parse_phase_next = gsfp_pkg::PH_ID;
          id_count_next    = 3'd0;
          running_xor_next = 8'd0;
        end else if (rx_byte == gsfp_pkg::SYNC_FIRST) begin
          parse_phase_next = gsfp_pkg::PH_SYNC2;
        end
      end
    endcase

    res.sentence_kind = current_kind_next;
    res.ack_confirmed = confirmed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase  <= gsfp_pkg::PH_IDLE;
      id_count     <= 3'd0;
      id_chars     <= '{default: 8'd0};
      running_xor  <= 8'd0;
      current_kind <= 3'd0;
      comma_count  <= 8'd0;
      frame_class  <= 8'd0;
      frame_msg_id <= 8'd0;
      body_length  <= 16'd0;
      body_count   <= 16'd0;
      acked_class  <= 8'd0;
      acked_msg    <= 8'd0;
      confirmed    <= 1'b0;
    end else if (step) begin
      parse_phase  <= parse_phase_next;
      id_count     <= id_count_next;
      id_chars     <= id_chars_next;
      running_xor  <= running_xor_next;
      current_kind <= current_kind_next;
      comma_count  <= comma_count_next;
      frame_class  <= frame_class_next;
      frame_msg_id <= frame_msg_id_next;
      body_length  <= body_length_next;
      body_count   <= body_count_next;
      acked_class  <= acked_class_next;
      acked_msg    <= acked_msg_next;
      confirmed    <= confirmed_next;
    end
  end

endmodule

### rtl/gnss_sentence_frame_parser_unit.sv
`timescale 1ns / 1ps
// Top level: input register, parser step, result register and stream handshake.
// Depends on gsfp_pkg and gsfp_step.
//
//  channel | dir | payload
//  s_*     | in  | tdata[7:0] rx_byte
//  m_*     | out | tlast sentence_end, tdata[21:0] result fields
//
// One byte per cycle sustained while results are taken; each byte passes the input register, then the result register.
// The parser state updates once per byte as it moves from the input register
// to the result register; that single update sets the rate.
// rst is synchronous and clears the full flags of both registers and all parser state.
// A stalled result holds; the input register still takes a request when the
// result is taken in the same cycle.
module gnss_sentence_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic        m_tlast,   // sentence_end
  output logic [23:0] m_tdata    // [0] checksum_good, [3:1] sentence_kind,
                                 // [4] data_byte_valid, [12:5] field_index,
                                 // [20:13] data_char, [21] ack_confirmed, [23:22] zero
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              out_full;
  gsfp_pkg::result_t out_res;
  gsfp_pkg::result_t step_res;
  logic              advance;

  assign advance  = in_full && (!out_full || m_tready);
  assign s_tready = !in_full || advance;

  gsfp_step u_step (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_full <= 1'b1;
      end else if (m_tready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_full;
  assign m_tlast  = out_res.sentence_end;
  assign m_tdata  = {2'b00, out_res.ack_confirmed, out_res.data_char, out_res.field_index,
                     out_res.data_byte_valid, out_res.sentence_kind, out_res.checksum_good};

endmodule

### rtl/gsfp_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the parser top level, attached by bind.
// Depends on gnss_sentence_frame_parser_unit ports only.
module gsfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic        m_tlast,
  input logic [23:0] m_tdata
);

  logic seen_ack;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_ack <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[21]) begin
      seen_ack <= 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  a_ack_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen_ack |-> m_tdata[21])
    else $error("confirmed flag dropped");

  a_no_data_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[4] |-> m_tdata[20:5] == 16'd0)
    else $error("field index or char set without data byte");

  a_end_not_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[4])
    else $error("sentence end marked as data byte");

endmodule

bind gnss_sentence_frame_parser_unit gsfp_checker u_gsfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast),
  .m_tdata  (m_tdata)
);
